/* design/lgq_pkg.sv */
`default_nettype none
package lgq_pkg;

  localparam int POS_W    = 23;
  localparam int BEAT_W   = 32;
  localparam int MOD_STEPS = 32;

  localparam logic [1:0] CMD_GATE  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;

  localparam logic [2:0] REG_METER = 3'd0;
  localparam logic [2:0] REG_BARS  = 3'd1;
  localparam logic [2:0] REG_GATES = 3'd2;
  localparam logic [2:0] REG_LIVE  = 3'd3;
  localparam logic [2:0] REG_GRID  = 3'd4;

  // 1/64 beat in 16.16
  localparam logic [POS_W-1:0] MIN_GATE = 23'd1024;

  typedef struct packed {
    logic [1:0]        command;
    logic [BEAT_W-1:0] beat_position;
    logic [1:0]        voice_index;
    logic              gate_on;
  } in_item_t;

  typedef struct packed {
    logic             event_valid;
    logic [POS_W-1:0] event_position;
    logic [1:0]       event_voice;
    logic             event_gate_on;
    logic             cap_reached;
    logic             recording_active;
  } out_item_t;

  typedef struct packed {
    logic [2:0] addr;
    logic [4:0] wdata;
  } cfg_req_t;

  typedef struct packed {
    logic              start;
    logic [BEAT_W-1:0] dividend;
    logic [POS_W-1:0]  divisor;
  } mod_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [POS_W-1:0] remainder;
  } mod_rsp_t;

  // beats per bar counted in half beats
  function automatic logic [3:0] half_beats(input logic [2:0] meter);
    logic [3:0] hb;
    case (meter)
      3'd0:    hb = 4'd6;
      3'd1:    hb = 4'd8;
      3'd2:    hb = 4'd10;
      3'd3:    hb = 4'd7;
      3'd4:    hb = 4'd9;
      3'd5:    hb = 4'd11;
      default: hb = 4'd8;
    endcase
    return hb;
  endfunction

endpackage
`default_nettype wire

/* design/lgq_stream_if.sv */
`default_nettype none
interface lgq_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/lgq_serial_mod.sv */
`default_nettype none
module lgq_serial_mod (
  input  wire               clk,
  input  wire               rst_n,
  input  lgq_pkg::mod_req_t req,
  output lgq_pkg::mod_rsp_t rsp
);
  import lgq_pkg::*;

  localparam int CNT_W = $clog2(MOD_STEPS + 1);

  logic [BEAT_W-1:0] dvd_r;
  logic [POS_W-1:0]  dsr_r;
  logic [POS_W-1:0]  rem_r;
  logic [POS_W-1:0]  rem_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [POS_W:0]    trial;

  // one dividend bit per cycle, restoring remainder
  assign trial   = {rem_r, dvd_r[BEAT_W-1]};
  assign rem_nxt = (trial >= {1'b0, dsr_r}) ? POS_W'(trial - {1'b0, dsr_r})
                                            : trial[POS_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(MOD_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dsr_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[BEAT_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign rsp.busy      = busy_r;
  assign rsp.done      = done_r;
  assign rsp.remainder = rem_r;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rem_r < dsr_r)
    else $error("partial remainder reached divisor");

  a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r))
    else $error("done without a finished pass");

endmodule
`default_nettype wire

/* design/live_gate_event_quantizer.sv */
`default_nettype none
// path: start/stop, ignored and dropped requests go from accept straight to S_FIN;
//   a recorded gate without live quantize waits in S_MOD1, a quantized gate-on in S_MOD1 and S_MOD2,
//   a quantized gate-off in S_MOD1, then passes S_DUR, S_SUM and S_MOD2
// throughput: one request at a time, the next is taken the cycle after the result is registered;
//   set by the 32-step bit-serial remainder unit, run once or twice per gate
// reset: synchronous active low; config registers return to defaults, count and flags clear,
//   per-voice on positions clear to zero
module live_gate_event_quantizer #(
  parameter int STORE_CAPACITY = 2048,
  parameter int VOICE_COUNT    = 4
) (
  input wire           clk,
  input wire           rst_n,
  lgq_stream_if.sink   in_ch,
  lgq_stream_if.source out_ch,
  lgq_stream_if.sink   cfg_ch
);
  import lgq_pkg::*;

  localparam int CNT_W  = $clog2(STORE_CAPACITY + 1);
  localparam int VIDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_MOD1, S_DUR, S_SUM, S_MOD2, S_FIN
  } state_t;

  state_t state_r;

  logic [2:0] meter_r;
  logic [4:0] bars_r;
  logic       gates_r;
  logic       live_r;
  logic [1:0] grid_r;

  logic [CNT_W-1:0] cnt_r;
  logic             rec_r;
  logic             cap_r;

  logic [POS_W-1:0] raw_on_r  [VOICE_COUNT];
  logic [POS_W-1:0] snap_on_r [VOICE_COUNT];

  logic [1:0]       voice_r;
  logic             on_r;
  logic             ev_r;
  logic [POS_W-1:0] len_r;
  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] dur_r;
  logic [POS_W-1:0] res_pos_r;
  logic             out_valid_r;
  out_item_t        out_data_r;

  logic             in_fire;
  logic             cfg_fire;
  logic             out_free;
  logic [4:0]       bars_sat;
  logic [7:0]       len_half;
  logic [POS_W-1:0] len_c;
  logic             voice_ok;
  logic             gate_req;
  logic             store_full;
  logic [3:0]       voice_x;
  logic [VIDX_W-1:0] vidx;

  logic [16:0]      grid_g;
  logic [15:0]      grid_m;
  logic [POS_W:0]   snap_c;
  logic [24:0]      d0;
  logic [24:0]      d1;
  logic [24:0]      dsel;
  logic [POS_W-1:0] dur_nxt;
  logic [POS_W:0]   sum_c;

  mod_req_t mreq;
  mod_rsp_t mrsp;

  lgq_serial_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign cfg_fire = cfg_ch.valid && cfg_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // loop length = half beats * bars * 32768
  assign bars_sat = (bars_r == 5'd0) ? 5'd1 : ((bars_r > 5'd16) ? 5'd16 : bars_r);
  assign len_half = {4'd0, half_beats(meter_r)} * {3'd0, bars_sat};
  assign len_c    = {len_half, 15'd0};

  assign voice_ok   = {3'b000, in_ch.data.voice_index} < 5'(VOICE_COUNT);
  assign gate_req   = (in_ch.data.command == CMD_GATE) && rec_r && gates_r && voice_ok;
  assign store_full = cnt_r >= CNT_W'(STORE_CAPACITY);

  assign voice_x = {2'b00, voice_r};
  assign vidx    = voice_x[VIDX_W-1:0];

  // nearest grid point, tie to the earlier one
  always_comb begin
    logic [15:0]      frac;
    logic [POS_W-1:0] lower;
    grid_g = 17'h10000 >> grid_r;
    grid_m = 16'(grid_g - 17'd1);
    frac   = mrsp.remainder[15:0] & grid_m;
    lower  = mrsp.remainder & ~{7'd0, grid_m};
    snap_c = {1'b0, lower} + ((frac > grid_g[16:1]) ? {7'd0, grid_g} : 24'd0);
  end

  // raw duration, wrapped once, held to the minimum gate
  assign d0   = {2'b00, pos_r} - {2'b00, raw_on_r[vidx]};
  assign d1   = d0 + {2'b00, len_r};
  assign dsel = d0[24] ? d1 : d0;
  assign dur_nxt = ($signed(dsel) < $signed({2'b00, MIN_GATE})) ? MIN_GATE
                                                                 : dsel[POS_W-1:0];
  assign sum_c = {1'b0, snap_on_r[vidx]} + {1'b0, dur_r};

  always_comb begin
    mreq.start    = 1'b0;
    mreq.dividend = in_ch.data.beat_position;
    mreq.divisor  = len_c;
    case (state_r)
      S_IDLE: begin
        mreq.start = in_fire && gate_req && !store_full;
      end
      S_MOD1: begin
        mreq.start    = mrsp.done && live_r && on_r;
        mreq.dividend = BEAT_W'(snap_c);
        mreq.divisor  = len_r;
      end
      S_SUM: begin
        mreq.start    = 1'b1;
        mreq.dividend = BEAT_W'(sum_c);
        mreq.divisor  = len_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      meter_r     <= 3'd1;
      bars_r      <= 5'd1;
      gates_r     <= 1'b1;
      live_r      <= 1'b0;
      grid_r      <= 2'd1;
      cnt_r       <= '0;
      rec_r       <= 1'b0;
      cap_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int v = 0; v < VOICE_COUNT; v++) begin
        raw_on_r[v]  <= '0;
        snap_on_r[v] <= '0;
      end
    end else begin
      if (cfg_fire) begin
        unique case (cfg_ch.data.addr)
          REG_METER: meter_r <= cfg_ch.data.wdata[2:0];
          REG_BARS:  bars_r  <= cfg_ch.data.wdata;
          REG_GATES: gates_r <= cfg_ch.data.wdata[0];
          REG_LIVE:  live_r  <= cfg_ch.data.wdata[0];
          REG_GRID:  grid_r  <= cfg_ch.data.wdata[1:0];
          default: ;
        endcase
      end

      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            voice_r <= in_ch.data.voice_index;
            on_r    <= in_ch.data.gate_on;
            len_r   <= len_c;
            ev_r    <= 1'b0;
            state_r <= S_FIN;
            unique case (in_ch.data.command)
              CMD_START: begin
                cnt_r <= '0;
                cap_r <= 1'b0;
                rec_r <= 1'b1;
              end
              CMD_STOP: begin
                rec_r <= 1'b0;
              end
              CMD_GATE: begin
                if (gate_req) begin
                  if (store_full) begin
                    cap_r <= 1'b1;
                    rec_r <= 1'b0;
                  end else begin
                    cnt_r   <= cnt_r + 1'b1;
                    ev_r    <= 1'b1;
                    state_r <= S_MOD1;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_MOD1: begin
          if (mrsp.done) begin
            pos_r <= mrsp.remainder;
            if (!live_r) begin
              res_pos_r <= mrsp.remainder;
              state_r   <= S_FIN;
            end else if (on_r) begin
              raw_on_r[vidx] <= mrsp.remainder;
              state_r        <= S_MOD2;
            end else begin
              state_r <= S_DUR;
            end
          end
        end
        S_DUR: begin
          dur_r   <= dur_nxt;
          state_r <= S_SUM;
        end
        S_SUM: begin
          state_r <= S_MOD2;
        end
        S_MOD2: begin
          if (mrsp.done) begin
            res_pos_r <= mrsp.remainder;
            if (on_r) begin
              snap_on_r[vidx] <= mrsp.remainder;
            end
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_data_r.event_valid      <= ev_r;
            out_data_r.event_position   <= ev_r ? res_pos_r : '0;
            out_data_r.event_voice      <= ev_r ? voice_r : 2'd0;
            out_data_r.event_gate_on    <= ev_r && on_r;
            out_data_r.cap_reached      <= cap_r;
            out_data_r.recording_active <= rec_r;
            state_r                     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_one_request_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready)
    else $error("request taken while one is in progress");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STORE_CAPACITY))
    else $error("stored count above capacity");

  a_position_in_loop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && ev_r) |-> res_pos_r < len_r)
    else $error("recorded position outside the loop");

  a_mod_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    mrsp.done |-> (state_r == S_MOD1 || state_r == S_MOD2))
    else $error("remainder finished outside a wait state");

  a_mod_free_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mrsp.busy)
    else $error("remainder unit busy while idle");

endmodule
`default_nettype wire

/* tb/live_gate_event_quantizer_tb.sv */
`timescale 1ns / 1ps
`default_nettype none
module live_gate_event_quantizer_tb;
  import lgq_pkg::*;

  localparam int STORE_CAP      = 2048;
  localparam int VOICES         = 4;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_SHOWN      = 10;

  typedef struct {
    bit         is_cfg;
    logic [2:0] addr;
    logic [4:0] val;
    in_item_t   req;
    bit         known;
    out_item_t  exp_out;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  lgq_stream_if #(.payload_t(in_item_t))  in_ch ();
  lgq_stream_if #(.payload_t(out_item_t)) out_ch ();
  lgq_stream_if #(.payload_t(cfg_req_t))  cfg_ch ();

  live_gate_event_quantizer #(
    .STORE_CAPACITY(STORE_CAP),
    .VOICE_COUNT(VOICES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always #5 clk = ~clk;

  // shadow copy of the block's registers and recording state
  logic [2:0]  reg_meter;
  logic [4:0]  reg_bars;
  logic        reg_gates;
  logic        reg_live;
  logic [1:0]  reg_grid;
  logic [31:0] voice_raw_on [VOICES];
  logic [31:0] voice_snap_on [VOICES];
  int unsigned rec_count;
  logic        rec_on;
  logic        cap_on;

  out_item_t   pending_events[$];
  script_row_t script_rows[$];
  int          err_count = 0;
  int          burst_left = 0;
  int          useful_sent = 0;
  int          total_sent = 0;
  int          quiet_cycles = 0;
  logic [8:0]  stall_phase = '0;
  logic [1:0]  stall_mode = '0;

  function automatic logic [31:0] loop_len();
    logic [31:0] bars;
    logic [31:0] per_bar;
    bars = 32'(reg_bars);
    if (bars < 1) bars = 1;
    if (bars > 16) bars = 16;
    case (reg_meter)
      3'd0:    per_bar = 32'd196608;
      3'd2:    per_bar = 32'd327680;
      3'd3:    per_bar = 32'd229376;
      3'd4:    per_bar = 32'd294912;
      3'd5:    per_bar = 32'd360448;
      default: per_bar = 32'd262144;
    endcase
    return per_bar * bars;
  endfunction

  function automatic out_item_t predict_event(input in_item_t r);
    out_item_t   o;
    logic [31:0] len;
    logic [31:0] pos;
    logic [31:0] step;
    logic [31:0] lower;
    logic [31:0] held;
    o = '0;
    case (r.command)
      CMD_START: begin
        rec_count = 0;
        cap_on = 1'b0;
        rec_on = 1'b1;
      end
      CMD_STOP: rec_on = 1'b0;
      CMD_GATE: begin
        if (rec_on && reg_gates && r.voice_index < VOICES) begin
          len = loop_len();
          if (rec_count >= STORE_CAP) begin
            cap_on = 1'b1;
            rec_on = 1'b0;
          end else begin
            pos = r.beat_position % len;
            if (reg_live && r.gate_on) begin
              voice_raw_on[r.voice_index] = pos;
              step = 32'd65536 >> reg_grid;
              lower = pos - (pos % step);
              // a tie goes to the earlier grid point
              pos = ((pos <= lower + step / 2) ? lower : lower + step) % len;
              voice_snap_on[r.voice_index] = pos;
            end else if (reg_live) begin
              // still negative after one wrap ends up at the minimum gate
              if (pos >= voice_raw_on[r.voice_index])
                held = pos - voice_raw_on[r.voice_index];
              else if (pos + len >= voice_raw_on[r.voice_index])
                held = pos + len - voice_raw_on[r.voice_index];
              else
                held = 32'd0;
              if (held < 32'd1024) held = 32'd1024;
              pos = (voice_snap_on[r.voice_index] + held) % len;
            end
            rec_count++;
            o.event_valid = 1'b1;
            o.event_position = pos[POS_W-1:0];
            o.event_voice = r.voice_index;
            o.event_gate_on = r.gate_on;
          end
        end
      end
      default: ;
    endcase
    o.cap_reached = cap_on;
    o.recording_active = rec_on;
    return o;
  endfunction

  // adds a random whole number of loops without leaving 32 bits
  function automatic logic [31:0] lift_beat(input logic [31:0] pos, input logic [31:0] len);
    logic [31:0] turns;
    turns = (32'hFFFF_FFFF - pos) / len;
    if ($urandom_range(0, 2) == 0) return pos;
    return pos + len * $urandom_range(0, turns);
  endfunction

  task automatic send_request(input in_item_t r, input bit fixed, input out_item_t fixed_exp,
                              output out_item_t pred);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data <= r;
    do @(posedge clk); while (!in_ch.ready);
    pred = predict_event(r);
    pending_events.push_back(fixed ? fixed_exp : pred);
    total_sent++;
    if (pred.event_valid || r.command == CMD_START || r.command == CMD_STOP)
      useful_sent++;
  endtask

  task automatic send_gate(input logic [1:0] cmd, input logic [31:0] beat,
                           input logic [1:0] voice, input logic on);
    in_item_t  r;
    out_item_t pred;
    r.command = cmd;
    r.beat_position = beat;
    r.voice_index = voice;
    r.gate_on = on;
    send_request(r, 1'b0, '0, pred);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [4:0] val, input bit last);
    cfg_req_t w;
    w.addr = addr;
    w.wdata = val;
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= w;
    do @(posedge clk); while (!cfg_ch.ready);
    case (addr)
      REG_METER: reg_meter = val[2:0];
      REG_BARS:  reg_bars = val;
      REG_GATES: reg_gates = val[0];
      REG_LIVE:  reg_live = val[0];
      REG_GRID:  reg_grid = val[1:0];
      default: ;
    endcase
    if (last) cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
  endtask

  function automatic void add_setting(input logic [2:0] addr, input logic [4:0] val);
    script_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.addr = addr;
    row.val = val;
    script_rows.push_back(row);
  endfunction

  function automatic void add_request(input logic [1:0] cmd, input logic [31:0] beat,
                                      input logic [1:0] voice, input logic on,
                                      input bit known, input out_item_t exp_out);
    script_row_t row;
    row = '{default: '0};
    row.req.command = cmd;
    row.req.beat_position = beat;
    row.req.voice_index = voice;
    row.req.gate_on = on;
    row.known = known;
    row.exp_out = exp_out;
    script_rows.push_back(row);
  endfunction

  task automatic run_script();
    script_row_t row;
    out_item_t   pred;
    int          n;
    n = script_rows.size();
    for (int i = 0; i < n; i++) begin
      row = script_rows[i];
      if (row.is_cfg) begin
        if (i == 0 || !script_rows[i-1].is_cfg) wait_idle();
        cfg_write(row.addr, row.val, (i == n - 1) || !script_rows[i+1].is_cfg);
      end else begin
        send_request(row.req, row.known, row.exp_out, pred);
      end
    end
  endtask

  task automatic configure(input logic [2:0] meter, input logic [4:0] bars, input logic gates,
                           input logic live, input logic [1:0] grid);
    wait_idle();
    cfg_write(REG_METER, {2'b0, meter}, 1'b0);
    cfg_write(REG_BARS, bars, 1'b0);
    cfg_write(REG_GATES, {4'b0, gates}, 1'b0);
    cfg_write(REG_LIVE, {4'b0, live}, 1'b0);
    cfg_write(REG_GRID, {3'b0, grid}, 1'b1);
  endtask

  // mostly on/off pairs per voice, with noise and broken pairs mixed in
  task automatic run_phase(input int n);
    int          first_useful;
    int          first_sent;
    logic [31:0] len;
    logic [31:0] step;
    logic [31:0] on_pos;
    logic [31:0] held;
    logic [1:0]  v;
    first_useful = useful_sent;
    first_sent = total_sent;
    send_gate(CMD_START, $urandom, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    while (useful_sent - first_useful < n && total_sent - first_sent < 3 * n) begin
      len = loop_len();
      step = 32'd65536 >> reg_grid;
      if ($urandom_range(0, 99) < 10) begin
        send_gate(2'($urandom_range(0, 3)), $urandom, 2'($urandom_range(0, 3)),
                  1'($urandom_range(0, 1)));
      end else begin
        if (!rec_on) send_gate(CMD_START, $urandom, 2'($urandom_range(0, 3)), 1'b0);
        v = 2'($urandom_range(0, 3));
        on_pos = $urandom_range(0, len - 1);
        if ($urandom_range(0, 3) == 0)
          on_pos = ((on_pos / step) * step + step / 2 - 1 + $urandom_range(0, 2)) % len;
        send_gate(CMD_GATE, lift_beat(on_pos, len), v, 1'b1);
        if ($urandom_range(0, 2) == 0)
          send_gate(CMD_GATE, $urandom, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        case ($urandom_range(0, 3))
          0:       held = $urandom_range(0, 2047);
          1:       held = $urandom_range(0, len - 1);
          2:       held = $urandom_range(len - 2048, len - 1);
          default: held = $urandom_range(0, 4 * 65536);
        endcase
        // an occasional lost gate-off leaves the voice hanging
        if ($urandom_range(0, 9) != 0)
          send_gate(CMD_GATE, lift_beat((on_pos + held) % len, len), v, 1'b0);
      end
    end
  endtask

  always @(posedge clk) begin : result_check
    out_item_t got;
    out_item_t want;
    stall_phase <= stall_phase + 1'b1;
    if (stall_phase == '0) stall_mode <= 2'($urandom_range(0, 2));
    case (stall_mode)
      2'd0:    out_ch.ready <= 1'b1;
      2'd1:    out_ch.ready <= ($urandom_range(0, 9) < 7);
      default: out_ch.ready <= (stall_phase[2:0] < 3'd3);
    endcase
    if (out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_events.size() == 0) begin
        err_count++;
        if (err_count <= MAX_SHOWN)
          $display("unexpected result: valid %0b pos %h voice %0d on %0b cap %0b rec %0b",
                   got.event_valid, got.event_position, got.event_voice,
                   got.event_gate_on, got.cap_reached, got.recording_active);
      end else begin
        want = pending_events.pop_front();
        if (got.event_valid !== want.event_valid || got.event_position !== want.event_position
            || got.event_voice !== want.event_voice || got.event_gate_on !== want.event_gate_on
            || got.cap_reached !== want.cap_reached
            || got.recording_active !== want.recording_active) begin
          err_count++;
          if (err_count <= MAX_SHOWN) begin
            $display("mismatch at %0t: expected valid %0b pos %h voice %0d on %0b cap %0b rec %0b",
                     $realtime, want.event_valid, want.event_position, want.event_voice,
                     want.event_gate_on, want.cap_reached, want.recording_active);
            $display("                 actual   valid %0b pos %h voice %0d on %0b cap %0b rec %0b",
                     got.event_valid, got.event_position, got.event_voice,
                     got.event_gate_on, got.cap_reached, got.recording_active);
          end
        end
      end
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    reg_meter = 3'd1;
    reg_bars = 5'd1;
    reg_gates = 1'b1;
    reg_live = 1'b0;
    reg_grid = 2'd1;
    for (int v = 0; v < VOICES; v++) begin
      voice_raw_on[v] = '0;
      voice_snap_on[v] = '0;
    end
    rec_count = 0;
    rec_on = 1'b0;
    cap_on = 1'b0;

    // reset defaults: 4/4, one bar, half-beat grid, live quantize off
    add_request(CMD_GATE, 32'h0, 2'd0, 1'b1, 1'b1, '0);
    add_request(2'd3, 32'hFFFF_FFFF, 2'd3, 1'b1, 1'b1, '0);
    add_request(CMD_STOP, 32'h0, 2'd0, 1'b0, 1'b1, '0);
    add_request(CMD_START, 32'h0, 2'd0, 1'b0, 1'b1,
                out_item_t'{1'b0, 23'd0, 2'd0, 1'b0, 1'b0, 1'b1});
    add_request(CMD_GATE, 32'h0, 2'd0, 1'b1, 1'b1,
                out_item_t'{1'b1, 23'd0, 2'd0, 1'b1, 1'b0, 1'b1});
    add_request(CMD_GATE, 32'hFFFF_FFFF, 2'd3, 1'b0, 1'b1,
                out_item_t'{1'b1, 23'h3FFFF, 2'd3, 1'b0, 1'b0, 1'b1});
    add_setting(REG_LIVE, 5'd1);
    // exact midpoint between grid points
    add_request(CMD_GATE, 32'h4000, 2'd1, 1'b1, 1'b1,
                out_item_t'{1'b1, 23'd0, 2'd1, 1'b1, 1'b0, 1'b1});
    add_request(CMD_GATE, 32'h4001, 2'd2, 1'b1, 1'b0, '0);
    // snaps onto the loop end
    add_request(CMD_GATE, 32'h3F000, 2'd0, 1'b1, 1'b0, '0);
    // shorter than the minimum gate
    add_request(CMD_GATE, 32'h4100, 2'd1, 1'b0, 1'b0, '0);
    // gate-off before its gate-on
    add_request(CMD_GATE, 32'h2000, 2'd2, 1'b0, 1'b0, '0);
    // voice with no gate-on since reset
    add_request(CMD_GATE, 32'h10000, 2'd3, 1'b0, 1'b0, '0);
    add_setting(REG_GRID, 5'd0);
    add_setting(REG_METER, 5'd5);
    add_setting(REG_BARS, 5'd31);
    add_request(CMD_GATE, 32'hFFFF_FFFF, 2'd0, 1'b1, 1'b0, '0);
    add_request(CMD_GATE, 32'h0001_2345, 2'd0, 1'b0, 1'b0, '0);
    add_setting(REG_GRID, 5'd3);
    add_setting(REG_METER, 5'd7);
    add_setting(REG_BARS, 5'd0);
    add_request(CMD_GATE, 32'hABCD_1234, 2'd1, 1'b1, 1'b0, '0);
    add_request(CMD_GATE, 32'h0, 2'd1, 1'b0, 1'b0, '0);
    add_setting(REG_METER, 5'd3);
    add_setting(REG_BARS, 5'd16);
    add_setting(REG_GRID, 5'd2);
    add_request(CMD_GATE, 32'h7FFF_E000, 2'd2, 1'b1, 1'b0, '0);
    add_setting(REG_GATES, 5'd0);
    add_request(CMD_GATE, 32'h100, 2'd0, 1'b1, 1'b1,
                out_item_t'{1'b0, 23'd0, 2'd0, 1'b0, 1'b0, 1'b1});
    add_setting(REG_GATES, 5'd1);
    add_request(2'd3, 32'h0, 2'd0, 1'b0, 1'b1,
                out_item_t'{1'b0, 23'd0, 2'd0, 1'b0, 1'b0, 1'b1});
    add_request(CMD_STOP, 32'h0, 2'd0, 1'b0, 1'b1, '0);
    add_request(CMD_GATE, 32'h8000, 2'd0, 1'b1, 1'b1, '0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    run_script();

    configure(3'd0, 5'd1, 1'b1, 1'b1, 2'd0);
    run_phase(25);
    configure(3'd5, 5'd16, 1'b1, 1'b1, 2'd3);
    run_phase(25);
    configure(3'd7, 5'd31, 1'b1, 1'b0, 2'd2);
    run_phase(25);
    configure(3'd6, 5'd0, 1'b1, 1'b1, 2'd1);
    run_phase(25);
    configure(3'd2, 5'd3, 1'b0, 1'b1, 2'd1);
    run_phase(10);
    for (int p = 0; p < 5; p++) begin
      configure(3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
                ($urandom_range(0, 5) != 0), ($urandom_range(0, 3) != 0),
                2'($urandom_range(0, 3)));
      run_phase(25);
    end

    // fill the store until the cap stops recording, then restart the pass
    configure(3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)), 1'b1,
              1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
    send_gate(CMD_START, $urandom, 2'd0, 1'b0);
    for (int k = 0; k < STORE_CAP + 4; k++)
      send_gate(CMD_GATE, $urandom, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    send_gate(CMD_START, $urandom, 2'd0, 1'b0);
    for (int k = 0; k < 8; k++)
      send_gate(CMD_GATE, $urandom, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));

    wait_idle();
    repeat (100) @(posedge clk);
    err_count += pending_events.size();
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
`default_nettype wire
